@@ rtl/core/cmed_pkg.sv @@
// Shared types and constants of the conditional 3x3 median filter.
package cmed_pkg;

    localparam int PIX_W          = 16;  // pixel field width on the stream
    localparam int WIDTH_CFG_W    = 12;  // frame_width register width
    localparam int HEIGHT_W       = 16;  // frame_height register width
    localparam int THRESH_W       = 19;  // spike_threshold register width
    localparam int DIFF_W         = THRESH_W + 1;
    localparam int ROW_W          = HEIGHT_W + 1;
    localparam int CFG_IDX_W      = 2;
    localparam int CFG_DATA_W     = THRESH_W;
    localparam int MIN_LOWER_COUNT = 6;

    localparam int RESET_FRAME_WIDTH  = 2048;
    localparam int RESET_FRAME_HEIGHT = 1;

    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SPIKE_THRESHOLD = 2'd2;

    // Which sides of the 3x3 window fall outside the frame.
    typedef struct packed {
        logic top;
        logic bottom;
        logic left;
        logic right;
    } border_t;

    // Control that travels with an item down the pipeline.
    typedef struct packed {
        logic    emit;
        logic    last;
        border_t border;
    } stage_ctl_t;

endpackage

@@ rtl/core/cmed_line_store.sv @@
// Two line stores holding the previous two rows of raw pixels.
module cmed_line_store #(
    parameter int DEPTH = 2048,
    parameter int DATA_W = 16,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  logic              aclk,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    input  logic [DATA_W-1:0] mid_wr_data,
    input  logic              up_wr_en,
    input  logic [ADDR_W-1:0] up_wr_addr,
    input  logic [DATA_W-1:0] up_wr_data,
    output logic [DATA_W-1:0] upper_q,
    output logic [DATA_W-1:0] middle_q
);

    logic [DATA_W-1:0] upper_mem [DEPTH];
    logic [DATA_W-1:0] middle_mem [DEPTH];

    // The middle row is read and rewritten at the same address; the read sees the old entry.
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            middle_q <= middle_mem[rd_addr];
            middle_mem[rd_addr] <= mid_wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            upper_q <= upper_mem[rd_addr];
        end
        if (up_wr_en) begin
            upper_mem[up_wr_addr] <= up_wr_data;
        end
    end

endmodule

@@ rtl/core/cmed_decide.sv @@
// Border replication, impulse test and 3x3 median selection for one window.
module cmed_decide #(
    parameter int PIXEL_BITS = 16
) (
    input  logic [PIXEL_BITS-1:0]               win [9],
    input  cmed_pkg::border_t                   border,
    input  logic signed [cmed_pkg::THRESH_W-1:0] threshold,
    output logic [PIXEL_BITS-1:0]               pix_out,
    output logic                                replaced
);

    logic [PIXEL_BITS-1:0] n [3][3];
    logic [PIXEL_BITS-1:0] lo [3];
    logic [PIXEL_BITS-1:0] md [3];
    logic [PIXEL_BITS-1:0] hi [3];
    logic [PIXEL_BITS-1:0] centre;
    logic [PIXEL_BITS-1:0] median;
    logic [3:0]            lower_cnt;
    logic [cmed_pkg::DIFF_W-1:0] diff;
    logic signed [cmed_pkg::DIFF_W-1:0] thr_ext;
    logic                  is_peak;
    logic                  diff_over;

    function automatic logic [PIXEL_BITS-1:0] min2(input logic [PIXEL_BITS-1:0] a,
                                                   input logic [PIXEL_BITS-1:0] b);
        return (a < b) ? a : b;
    endfunction

    function automatic logic [PIXEL_BITS-1:0] max2(input logic [PIXEL_BITS-1:0] a,
                                                   input logic [PIXEL_BITS-1:0] b);
        return (a > b) ? a : b;
    endfunction

    // Returns {high, middle, low}.
    function automatic logic [3*PIXEL_BITS-1:0] sort3(input logic [PIXEL_BITS-1:0] a,
                                                      input logic [PIXEL_BITS-1:0] b,
                                                      input logic [PIXEL_BITS-1:0] c);
        logic [PIXEL_BITS-1:0] x;
        logic [PIXEL_BITS-1:0] y;
        logic [PIXEL_BITS-1:0] t;
        x = min2(a, b);
        y = max2(a, b);
        t = min2(y, c);
        return {max2(y, c), max2(x, t), min2(x, t)};
    endfunction

    function automatic logic [PIXEL_BITS-1:0] mid3(input logic [PIXEL_BITS-1:0] a,
                                                   input logic [PIXEL_BITS-1:0] b,
                                                   input logic [PIXEL_BITS-1:0] c);
        return max2(min2(a, b), min2(max2(a, b), c));
    endfunction

    always_comb begin
        int rr;
        int cc;
        for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
                rr = r;
                cc = c;
                if (r == 0 && border.top) rr = 1;
                if (r == 2 && border.bottom) rr = 1;
                if (c == 0 && border.left) cc = 1;
                if (c == 2 && border.right) cc = 1;
                n[r][c] = win[rr * 3 + cc];
            end
        end
    end

    assign centre = n[1][1];

    always_comb begin
        lower_cnt = '0;
        for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
                if ((r != 1 || c != 1) && centre > n[r][c]) begin
                    lower_cnt = lower_cnt + 4'd1;
                end
            end
        end
    end

    // The true range of the difference fits the width, so wrap-around arithmetic is exact.
    assign diff = (cmed_pkg::DIFF_W'(centre) << 2) - cmed_pkg::DIFF_W'(n[0][1])
                - cmed_pkg::DIFF_W'(n[2][1]) - cmed_pkg::DIFF_W'(n[1][0])
                - cmed_pkg::DIFF_W'(n[1][2]);
    assign thr_ext   = {threshold[cmed_pkg::THRESH_W-1], threshold};
    assign diff_over = $signed(diff) > thr_ext;
    assign is_peak   = lower_cnt > 4'(cmed_pkg::MIN_LOWER_COUNT);

    always_comb begin
        for (int r = 0; r < 3; r++) begin
            {hi[r], md[r], lo[r]} = sort3(n[r][0], n[r][1], n[r][2]);
        end
        median = mid3(min2(min2(hi[0], hi[1]), hi[2]),
                      mid3(md[0], md[1], md[2]),
                      max2(max2(lo[0], lo[1]), lo[2]));
    end

    assign replaced = is_peak && diff_over;
    assign pix_out  = replaced ? median : centre;

endmodule

@@ rtl/core/conditional_median_3x3_core.sv @@
// Conditional 3x3 median filter: replaces isolated bright pixels by the window median.
// Throughput: one item per cycle unless a configuration write, the output-position divider
// or output back-pressure holds off input. A result passes the first stage, window stage and
// result register after the item that completes its window; results trail the pixels by
// frame_width+1 items, drain items flush the last row. Reset clears the counters, window and
// pipeline; the line stores are not cleared and need no clearing pass.
module conditional_median_3x3_core #(
    parameter int MAX_WIDTH  = 2048,
    parameter int PIXEL_BITS = 16
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [cmed_pkg::PIX_W-1:0]      s_tdata,   // [15:0] pixel_in
    input  logic [0:0]                      s_tuser,   // [0] drain
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [cmed_pkg::PIX_W-1:0]      m_tdata,   // [15:0] pixel_out
    output logic [0:0]                      m_tuser,   // [0] replaced
    output logic                            m_tlast,
    input  logic                            cfg_wr_en,
    input  logic [cmed_pkg::CFG_IDX_W-1:0]  cfg_wr_index,
    input  logic [cmed_pkg::CFG_DATA_W-1:0] cfg_wr_data
);

    localparam int COL_W    = $clog2(MAX_WIDTH);
    localparam int MAXW_EFF = (MAX_WIDTH < 4095) ? MAX_WIDTH : 4095;
    localparam int OCNT_W   = $clog2(MAXW_EFF * 65535 + 1);
    localparam int CMP_W    = ((COL_W > cmed_pkg::WIDTH_CFG_W) ? COL_W
                                                               : cmed_pkg::WIDTH_CFG_W) + 1;
    localparam int DCNT_W   = $clog2(OCNT_W + 1);
    localparam int WH_RESET = (MAXW_EFF < cmed_pkg::RESET_FRAME_WIDTH)
                            ? MAXW_EFF * cmed_pkg::RESET_FRAME_HEIGHT
                            : cmed_pkg::RESET_FRAME_WIDTH * cmed_pkg::RESET_FRAME_HEIGHT;
    localparam int ROW_W    = cmed_pkg::ROW_W;
    localparam int WCW      = cmed_pkg::WIDTH_CFG_W;

    // Configuration
    logic [WCW-1:0]                       frame_width_reg;
    logic [cmed_pkg::HEIGHT_W-1:0]        frame_height_reg;
    logic signed [cmed_pkg::THRESH_W-1:0] threshold_reg;
    logic [WCW-1:0]                       w_eff;
    logic [cmed_pkg::HEIGHT_W-1:0]        h_eff;
    logic [WCW+cmed_pkg::HEIGHT_W-1:0]    wh_full;
    logic [OCNT_W-1:0]                    wh_reg;

    // Position counters
    logic [COL_W-1:0]  in_col_reg,    in_col_next;
    logic [ROW_W-1:0]  in_row_reg,    in_row_next;
    logic [OCNT_W-1:0] out_count_reg, out_count_next;
    logic [ROW_W-1:0]  out_row_reg,   out_row_next;
    logic [COL_W-1:0]  out_col_reg,   out_col_next;

    // Divider that re-derives the output row and column after a configuration write
    logic              div_busy_reg, div_busy_next;
    logic [DCNT_W-1:0] div_cnt_reg,  div_cnt_next;
    logic [WCW-1:0]    div_rem_reg,  div_rem_next;
    logic [OCNT_W-1:0] div_quo_reg,  div_quo_next;
    logic [OCNT_W-1:0] div_num_reg,  div_num_next;
    logic [WCW:0]      trial;
    logic              trial_ge;
    logic [WCW:0]      trial_rem;
    logic [OCNT_W-1:0] quo_shift;
    logic [ROW_W-1:0]  quo_sat;

    // Input side
    logic                  drain;
    logic                  rows_done;
    logic                  item_live;
    logic                  live_emit;
    logic                  live_last;
    logic                  col_wrap;
    logic                  out_right;
    logic                  fwd_now;
    logic [PIXEL_BITS-1:0] pix_in;
    cmed_pkg::border_t     live_border;

    // First stage: line store access
    logic                  s1_valid_reg;
    cmed_pkg::stage_ctl_t  s1_ctl_reg;
    logic [PIXEL_BITS-1:0] s1_pix_reg;
    logic [COL_W-1:0]      s1_addr_reg;
    logic                  s1_fwd_reg;
    logic [PIXEL_BITS-1:0] s1_fwd_pix_reg;
    logic [PIXEL_BITS-1:0] upper_q;
    logic [PIXEL_BITS-1:0] middle_q;
    logic [PIXEL_BITS-1:0] upper_col;

    // Second stage: window
    logic                  s2_valid_reg;
    cmed_pkg::stage_ctl_t  s2_ctl_reg;
    logic [PIXEL_BITS-1:0] win_reg [9];
    logic                  s2_done;
    logic                  ld2;
    logic                  out_free;

    // Result register
    logic                  m_tvalid_reg;
    logic [PIXEL_BITS-1:0] out_pix_reg;
    logic                  out_repl_reg;
    logic                  out_last_reg;
    logic [PIXEL_BITS-1:0] dec_pix;
    logic                  dec_repl;

    // ---------------------------------------------------------------- configuration
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_width_reg  <= WCW'(cmed_pkg::RESET_FRAME_WIDTH);
            frame_height_reg <= cmed_pkg::HEIGHT_W'(cmed_pkg::RESET_FRAME_HEIGHT);
            threshold_reg    <= '0;
        end else if (cfg_wr_en) begin
            case (cfg_wr_index)
                cmed_pkg::REG_FRAME_WIDTH:     frame_width_reg  <= cfg_wr_data[WCW-1:0];
                cmed_pkg::REG_FRAME_HEIGHT:    frame_height_reg <=
                                                   cfg_wr_data[cmed_pkg::HEIGHT_W-1:0];
                cmed_pkg::REG_SPIKE_THRESHOLD: threshold_reg    <= cfg_wr_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        if (frame_width_reg == '0) begin
            w_eff = WCW'(1);
        end else if (CMP_W'(frame_width_reg) > CMP_W'(MAX_WIDTH)) begin
            w_eff = WCW'(MAX_WIDTH);
        end else begin
            w_eff = frame_width_reg;
        end
    end

    assign h_eff   = (frame_height_reg == '0) ? cmed_pkg::HEIGHT_W'(1) : frame_height_reg;
    assign wh_full = w_eff * h_eff;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wh_reg <= OCNT_W'(WH_RESET);
        end else begin
            wh_reg <= wh_full[OCNT_W-1:0];
        end
    end

    // ---------------------------------------------------------------- input decisions
    assign drain     = s_tuser[0];
    assign pix_in    = drain ? '0 : s_tdata[PIXEL_BITS-1:0];
    assign rows_done = in_row_reg >= ROW_W'(h_eff);
    assign s_tready  = !div_busy_reg && !cfg_wr_en && (!s1_valid_reg || ld2);
    // Pixels after the last row and drains before it are taken and dropped.
    assign item_live = s_tvalid && s_tready && (drain == rows_done);

    assign live_emit = (in_row_reg >= ROW_W'(2)) || (in_row_reg == ROW_W'(1) && in_col_reg != '0);
    assign live_last = (OCNT_W'(out_count_reg) + (OCNT_W + 1)'(1)) >= (OCNT_W + 1)'(wh_reg);
    assign col_wrap  = (CMP_W'(in_col_reg) + CMP_W'(1)) >= CMP_W'(w_eff);
    assign out_right = (CMP_W'(out_col_reg) + CMP_W'(1)) >= CMP_W'(w_eff);

    assign live_border.top    = out_row_reg == '0;
    assign live_border.bottom = ((ROW_W + 1)'(out_row_reg) + (ROW_W + 1)'(1))
                                >= (ROW_W + 1)'(h_eff);
    assign live_border.left   = out_col_reg == '0;
    assign live_border.right  = out_right;

    // ---------------------------------------------------------------- counters and divider
    assign trial     = {div_rem_reg, div_num_reg[OCNT_W-1]};
    assign trial_ge  = trial >= {1'b0, w_eff};
    assign trial_rem = trial_ge ? (trial - {1'b0, w_eff}) : trial;
    assign quo_shift = {div_quo_reg[OCNT_W-2:0], trial_ge};
    assign quo_sat   = (|quo_shift[OCNT_W-1:ROW_W]) ? '1 : quo_shift[ROW_W-1:0];

    always_comb begin
        in_col_next    = in_col_reg;
        in_row_next    = in_row_reg;
        out_count_next = out_count_reg;
        out_row_next   = out_row_reg;
        out_col_next   = out_col_reg;
        div_busy_next  = div_busy_reg;
        div_cnt_next   = div_cnt_reg;
        div_rem_next   = div_rem_reg;
        div_quo_next   = div_quo_reg;
        div_num_next   = div_num_reg;
        if (cfg_wr_en) begin
            div_busy_next = 1'b1;
            div_cnt_next  = DCNT_W'(OCNT_W);
            div_rem_next  = '0;
            div_quo_next  = '0;
            div_num_next  = out_count_reg;
        end else if (div_busy_reg) begin
            // One quotient bit per cycle.
            div_num_next = div_num_reg << 1;
            div_rem_next = trial_rem[WCW-1:0];
            div_quo_next = quo_shift;
            div_cnt_next = div_cnt_reg - DCNT_W'(1);
            if (div_cnt_reg == DCNT_W'(1)) begin
                div_busy_next = 1'b0;
                out_row_next  = quo_sat;
                out_col_next  = COL_W'(trial_rem);
            end
        end else if (item_live) begin
            if (col_wrap) begin
                in_col_next = '0;
                in_row_next = in_row_reg + ROW_W'(1);
            end else begin
                in_col_next = in_col_reg + COL_W'(1);
            end
            if (live_emit) begin
                if (live_last) begin
                    out_count_next = '0;
                    in_row_next    = '0;
                    in_col_next    = '0;
                    out_row_next   = '0;
                    out_col_next   = '0;
                end else begin
                    out_count_next = out_count_reg + OCNT_W'(1);
                    if (out_right) begin
                        out_col_next = '0;
                        out_row_next = (&out_row_reg) ? out_row_reg
                                                      : out_row_reg + ROW_W'(1);
                    end else begin
                        out_col_next = out_col_reg + COL_W'(1);
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_col_reg    <= '0;
            in_row_reg    <= '0;
            out_count_reg <= '0;
            out_row_reg   <= '0;
            out_col_reg   <= '0;
            div_busy_reg  <= 1'b0;
            div_cnt_reg   <= '0;
        end else begin
            in_col_reg    <= in_col_next;
            in_row_reg    <= in_row_next;
            out_count_reg <= out_count_next;
            out_row_reg   <= out_row_next;
            out_col_reg   <= out_col_next;
            div_busy_reg  <= div_busy_next;
            div_cnt_reg   <= div_cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        div_rem_reg <= div_rem_next;
        div_quo_reg <= div_quo_next;
        div_num_reg <= div_num_next;
    end

    // ---------------------------------------------------------------- line stores
    cmed_line_store #(
        .DEPTH  (MAX_WIDTH),
        .DATA_W (PIXEL_BITS)
    ) u_line_store (
        .aclk        (aclk),
        .rd_en       (item_live),
        .rd_addr     (in_col_reg),
        .mid_wr_data (pix_in),
        .up_wr_en    (ld2),
        .up_wr_addr  (s1_addr_reg),
        .up_wr_data  (middle_q),
        .upper_q     (upper_q),
        .middle_q    (middle_q)
    );

    // The upper row is written when the item leaves the first stage, after its read; a read of
    // that same column takes the pending value instead of the stale entry.
    assign fwd_now   = s1_valid_reg && ld2 && (s1_addr_reg == in_col_reg);
    assign upper_col = s1_fwd_reg ? s1_fwd_pix_reg : upper_q;

    // ---------------------------------------------------------------- stage 1
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (item_live) begin
            s1_valid_reg <= 1'b1;
        end else if (ld2) begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (item_live) begin
            s1_ctl_reg.emit   <= live_emit;
            s1_ctl_reg.last   <= live_last;
            s1_ctl_reg.border <= live_border;
            s1_pix_reg        <= pix_in;
            s1_addr_reg       <= in_col_reg;
            s1_fwd_reg        <= fwd_now;
            s1_fwd_pix_reg    <= middle_q;
        end
    end

    // ---------------------------------------------------------------- stage 2
    assign out_free = !m_tvalid_reg || m_tready;
    assign s2_done  = s2_valid_reg && (!s2_ctl_reg.emit || out_free);
    assign ld2      = s1_valid_reg && (!s2_valid_reg || s2_done);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s2_valid_reg <= 1'b0;
            for (int i = 0; i < 9; i++) begin
                win_reg[i] <= '0;
            end
        end else begin
            if (ld2) begin
                s2_valid_reg <= 1'b1;
                for (int r = 0; r < 3; r++) begin
                    win_reg[r * 3 + 0] <= win_reg[r * 3 + 1];
                    win_reg[r * 3 + 1] <= win_reg[r * 3 + 2];
                end
                win_reg[2] <= upper_col;
                win_reg[5] <= middle_q;
                win_reg[8] <= s1_pix_reg;
            end else if (s2_done) begin
                s2_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ld2) begin
            s2_ctl_reg <= s1_ctl_reg;
        end
    end

    cmed_decide #(
        .PIXEL_BITS (PIXEL_BITS)
    ) u_decide (
        .win       (win_reg),
        .border    (s2_ctl_reg.border),
        .threshold (threshold_reg),
        .pix_out   (dec_pix),
        .replaced  (dec_repl)
    );

    // ---------------------------------------------------------------- result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (s2_valid_reg && s2_ctl_reg.emit && out_free) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s2_valid_reg && s2_ctl_reg.emit && out_free) begin
            out_pix_reg  <= dec_pix;
            out_repl_reg <= dec_repl;
            out_last_reg <= s2_ctl_reg.last;
        end
    end

    assign m_tvalid   = m_tvalid_reg;
    assign m_tdata    = cmed_pkg::PIX_W'(out_pix_reg);
    assign m_tuser[0] = out_repl_reg;
    assign m_tlast    = out_last_reg;

    // ---------------------------------------------------------------- assertions
    a_frame_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        item_live && live_emit && live_last |=> out_count_reg == '0 && in_row_reg == '0)
        else $error("counters not cleared after the last item of a frame");

    a_out_col_in_row: assert property (@(posedge aclk) disable iff (!aresetn)
        !div_busy_reg |-> CMP_W'(out_col_reg) < CMP_W'(w_eff))
        else $error("output column outside the frame width");

    a_cfg_holds_input: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_wr_en |=> !(s_tvalid && s_tready))
        else $error("item accepted right after a configuration write");

endmodule

@@ test/conditional_median_3x3_core_tb.sv @@
// Self-checking testbench for the conditional 3x3 median core: random frames against a predictor.
module conditional_median_3x3_core_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_WIDTH     = 2048;
    localparam int PIXEL_BITS    = 16;
    localparam int CFG_W         = cmed_pkg::CFG_DATA_W;
    localparam int SETTLE_CYCLES = 8;
    localparam int ITEMS_PER_PHASE = 285;

    typedef logic [CFG_W-1:0] cfg_word_t;
    typedef bit [2:0][2:0][15:0] hood_t;

    typedef struct packed {
        logic [15:0] pixel;
        logic        replaced;
        logic        frame_end;
    } filt_result_t;

    logic                            aclk = 1'b0;
    logic                            aresetn = 1'b0;
    logic                            s_tvalid = 1'b0;
    logic                            s_tready;
    logic [cmed_pkg::PIX_W-1:0]      s_tdata = '0;   // [15:0] pixel_in
    logic [0:0]                      s_tuser = '0;   // [0] drain
    logic                            m_tvalid;
    logic                            m_tready = 1'b0;
    logic [cmed_pkg::PIX_W-1:0]      m_tdata;        // [15:0] pixel_out
    logic [0:0]                      m_tuser;        // [0] replaced
    logic                            m_tlast;
    logic                            cfg_wr_en = 1'b0;
    logic [cmed_pkg::CFG_IDX_W-1:0]  cfg_wr_index = '0;
    logic [CFG_W-1:0]                cfg_wr_data = '0;

    conditional_median_3x3_core #(
        .MAX_WIDTH (MAX_WIDTH),
        .PIXEL_BITS(PIXEL_BITS)
    ) u_top (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_index(cfg_wr_index),
        .cfg_wr_data (cfg_wr_data)
    );

    class despike_tracker;
        bit [15:0]    upper_line [MAX_WIDTH];
        bit [15:0]    middle_line [MAX_WIDTH];
        bit [15:0]    win [9];
        int unsigned  in_col;
        int unsigned  in_row;
        int unsigned  out_count;
        bit [cmed_pkg::WIDTH_CFG_W-1:0] width_reg;
        bit [cmed_pkg::HEIGHT_W-1:0]    height_reg;
        bit [cmed_pkg::THRESH_W-1:0]    thresh_reg;
        filt_result_t filtered_q [$];
        int           errors;

        function new();
            width_reg  = cmed_pkg::RESET_FRAME_WIDTH;
            height_reg = cmed_pkg::RESET_FRAME_HEIGHT;
            thresh_reg = '0;
            in_col     = 0;
            in_row     = 0;
            out_count  = 0;
            errors     = 0;
            foreach (win[i]) win[i] = '0;
        endfunction

        function void set_reg(logic [cmed_pkg::CFG_IDX_W-1:0] idx, cfg_word_t data);
            case (idx)
                cmed_pkg::REG_FRAME_WIDTH: begin
                    width_reg = data[cmed_pkg::WIDTH_CFG_W-1:0];
                end
                cmed_pkg::REG_FRAME_HEIGHT: begin
                    height_reg = data[cmed_pkg::HEIGHT_W-1:0];
                end
                cmed_pkg::REG_SPIKE_THRESHOLD: begin
                    thresh_reg = data[cmed_pkg::THRESH_W-1:0];
                end
                default: begin
                end
            endcase
        endfunction

        function int unsigned eff_w();
            if (width_reg == 0) return 1;
            if (width_reg > MAX_WIDTH) return MAX_WIDTH;
            return width_reg;
        endfunction

        function int unsigned eff_h();
            return (height_reg == 0) ? 1 : height_reg;
        endfunction

        // True once every pixel of the frame is in and only drain items are taken.
        function bit input_done();
            return in_row >= eff_h();
        endfunction

        function bit [15:0] min2(bit [15:0] a, bit [15:0] b);
            return (a < b) ? a : b;
        endfunction

        function bit [15:0] max2(bit [15:0] a, bit [15:0] b);
            return (a > b) ? a : b;
        endfunction

        function bit [15:0] mid3(bit [15:0] a, bit [15:0] b, bit [15:0] c);
            return max2(min2(a, b), min2(max2(a, b), c));
        endfunction

        function bit [15:0] median_of_nine(hood_t n);
            bit [15:0] lo_of_hi;
            bit [15:0] hi_of_lo;
            lo_of_hi = min2(min2(max2(max2(n[0][0], n[0][1]), n[0][2]),
                                 max2(max2(n[1][0], n[1][1]), n[1][2])),
                            max2(max2(n[2][0], n[2][1]), n[2][2]));
            hi_of_lo = max2(max2(min2(min2(n[0][0], n[0][1]), n[0][2]),
                                 min2(min2(n[1][0], n[1][1]), n[1][2])),
                            min2(min2(n[2][0], n[2][1]), n[2][2]));
            return mid3(lo_of_hi,
                        mid3(mid3(n[0][0], n[0][1], n[0][2]),
                             mid3(n[1][0], n[1][1], n[1][2]),
                             mid3(n[2][0], n[2][1], n[2][2])),
                        hi_of_lo);
        endfunction

        // Advances the window by one accepted item; returns 0 when the block ignores it.
        function bit accept_item(bit [15:0] pix, bit drain);
            int unsigned  w;
            int unsigned  h;
            int unsigned  k;
            int unsigned  orow;
            int unsigned  ocol;
            int unsigned  below;
            int           r;
            int           c;
            int           rr;
            int           cc;
            int           diff;
            bit           emit;
            hood_t        n;
            filt_result_t res;
            w = eff_w();
            h = eff_h();
            if (drain == (in_row < h)) return 1'b0;
            if (drain) pix = '0;
            k = (in_col < MAX_WIDTH) ? in_col : MAX_WIDTH - 1;
            for (r = 0; r < 3; r++) begin
                win[r * 3]     = win[r * 3 + 1];
                win[r * 3 + 1] = win[r * 3 + 2];
            end
            win[2] = upper_line[k];
            win[5] = middle_line[k];
            win[8] = pix;
            upper_line[k]  = middle_line[k];
            middle_line[k] = pix;

            emit = (in_row >= 2) || (in_row == 1 && in_col >= 1);
            if (in_col + 1 >= w) begin
                in_col = 0;
                in_row++;
            end else begin
                in_col++;
            end
            if (!emit) return 1'b1;

            // Borders are filled by repeating the centre row or column of the window.
            orow = out_count / w;
            ocol = out_count % w;
            for (r = 0; r < 3; r++) begin
                for (c = 0; c < 3; c++) begin
                    rr = r;
                    cc = c;
                    if (r == 0 && orow == 0) rr = 1;
                    if (r == 2 && orow + 1 >= h) rr = 1;
                    if (c == 0 && ocol == 0) cc = 1;
                    if (c == 2 && ocol + 1 >= w) cc = 1;
                    n[r][c] = win[rr * 3 + cc];
                end
            end

            res.pixel    = n[1][1];
            res.replaced = 1'b0;
            below = 0;
            for (r = 0; r < 3; r++) begin
                for (c = 0; c < 3; c++) begin
                    if ((r != 1 || c != 1) && n[1][1] > n[r][c]) below++;
                end
            end
            if (below > cmed_pkg::MIN_LOWER_COUNT) begin
                diff = 4 * int'(n[1][1]) - int'(n[0][1]) - int'(n[2][1])
                     - int'(n[1][0]) - int'(n[1][2]);
                if (diff > int'($signed(thresh_reg))) begin
                    res.pixel    = median_of_nine(n);
                    res.replaced = 1'b1;
                end
            end

            res.frame_end = (out_count + 1 >= w * h);
            if (res.frame_end) begin
                out_count = 0;
                in_row    = 0;
                in_col    = 0;
            end else begin
                out_count++;
            end
            filtered_q.push_back(res);
            return 1'b1;
        endfunction

        function void compare_field(string name, logic [15:0] want, logic [15:0] got);
            if (got !== want) begin
                $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, name, want, got);
                errors++;
            end
        endfunction

        function void check_output(logic [15:0] pixel, logic replaced, logic frame_end);
            filt_result_t want;
            if (filtered_q.size() == 0) begin
                $display("%0t ns: unexpected output, expected none, got pixel %0d",
                         $time, pixel);
                errors++;
                return;
            end
            want = filtered_q.pop_front();
            compare_field("pixel_out", want.pixel, pixel);
            compare_field("replaced", 16'(want.replaced), 16'(replaced));
            compare_field("frame_end", 16'(want.frame_end), 16'(frame_end));
        endfunction
    endclass

    despike_tracker tracker;

    int          tx_idle_pct = 0;
    int          rx_idle_pct = 0;
    int unsigned taken_items = 0;

    // Texture of the current frame's pixels.
    bit          full_random = 1'b0;
    int          bg = 0;
    int          spread = 0;
    int          spike_pct = 0;
    logic [15:0] pattern_q [$];

    initial begin
        forever #6 aclk = ~aclk;
    end

    always @(negedge aclk) begin
        m_tready <= ($urandom_range(99) >= rx_idle_pct);
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            tracker.check_output(m_tdata, m_tuser[0], m_tlast);
        end
    end

    function automatic logic [15:0] next_pixel();
        int v;
        if (pattern_q.size() != 0) return pattern_q.pop_front();
        if (full_random) return 16'($urandom());
        v = bg + $urandom_range(0, spread);
        if ($urandom_range(99) < spike_pct) v = v + $urandom_range(spread + 1, 65535);
        return (v > 65535) ? 16'hFFFF : 16'(v);
    endfunction

    task automatic pick_texture();
        int pick;
        pick = $urandom_range(99);
        full_random = ($urandom_range(99) < 20);
        bg = (pick < 10) ? 0 : (pick < 20) ? $urandom_range(64000, 65535)
                                            : $urandom_range(0, 65535);
        case ($urandom_range(3))
            0: spread = 0;
            1: spread = 3;
            2: spread = 50;
            default: spread = 2000;
        endcase
        spike_pct = $urandom_range(5, 25);
    endtask

    task automatic push_item(input logic [15:0] pix, input logic drain);
        @(negedge aclk);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid   <= 1'b1;
        s_tdata    <= pix;
        s_tuser[0] <= drain;
        @(posedge aclk);
        while (s_tready !== 1'b1) @(posedge aclk);
        if (tracker.accept_item(pix, drain)) taken_items++;
    endtask

    task automatic stop_sending();
        @(negedge aclk);
        s_tvalid <= 1'b0;
    endtask

    // Stray drain items mixed into the pixels are ignored by the block.
    task automatic send_pixels(input int noise_pct);
        while (!tracker.input_done()) begin
            if ($urandom_range(99) < noise_pct) push_item(16'($urandom()), 1'b1);
            else push_item(next_pixel(), 1'b0);
        end
    endtask

    // Stray pixels during the flush are ignored until the frame end has left.
    task automatic send_drains(input int noise_pct);
        while (tracker.input_done()) begin
            if ($urandom_range(99) < noise_pct) push_item(16'($urandom()), 1'b0);
            else push_item(16'($urandom()), 1'b1);
        end
    endtask

    task automatic stream_frame(input int noise_pct);
        send_pixels(noise_pct);
        send_drains(noise_pct);
    endtask

    task automatic write_reg(input logic [cmed_pkg::CFG_IDX_W-1:0] idx, input cfg_word_t data);
        @(negedge aclk);
        cfg_wr_en    <= 1'b1;
        cfg_wr_index <= idx;
        cfg_wr_data  <= data;
        tracker.set_reg(idx, data);
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    // Registers are only written once every result of the last frame has left.
    task automatic configure(input int w, input int h, input int thr);
        stop_sending();
        while (tracker.filtered_q.size() != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
        write_reg(cmed_pkg::REG_FRAME_WIDTH, cfg_word_t'(w));
        write_reg(cmed_pkg::REG_FRAME_HEIGHT, cfg_word_t'(h));
        write_reg(cmed_pkg::REG_SPIKE_THRESHOLD, cfg_word_t'(thr));
    endtask

    task automatic random_frame();
        int pick;
        int w;
        int h;
        int thr;
        pick = $urandom_range(99);
        w = (pick < 80) ? $urandom_range(1, 12) : (pick < 93) ? $urandom_range(13, 40) : 0;
        pick = $urandom_range(99);
        h = (pick < 85) ? $urandom_range(1, 8) : (pick < 93) ? $urandom_range(9, 20) : 0;
        pick = $urandom_range(99);
        if (pick < 65) thr = $urandom_range(0, 3000) - 1000;
        else if (pick < 75) thr = -262140;
        else if (pick < 85) thr = 262140;
        else thr = $urandom_range(0, 524280) - 262140;
        configure(w, h, thr);
        pick_texture();
        stream_frame(3);
    endtask

    initial begin
        int          phase;
        int unsigned start_count;
        int          waited;
        tracker = new();
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        tx_idle_pct = 24;
        rx_idle_pct = 45;

        // First frame keeps the reset height and threshold: a single short row.
        write_reg(cmed_pkg::REG_FRAME_WIDTH, cfg_word_t'(7));
        pick_texture();
        stream_frame(0);

        // A lone spike whose neighbour difference equals the threshold stays.
        configure(3, 3, 262140);
        pattern_q = '{16'd0, 16'd0, 16'd0, 16'd0, 16'hFFFF, 16'd0, 16'd0, 16'd0, 16'd0};
        push_item(16'h1234, 1'b1);
        send_pixels(0);
        push_item(16'hFFFF, 1'b0);
        send_drains(0);

        // Zero width and height act as a single pixel.
        configure(0, 0, -262140);
        pattern_q = '{16'hFFFF};
        stream_frame(0);

        // One below the difference, the spike is replaced by the median.
        configure(3, 3, 262139);
        pattern_q = '{16'd0, 16'd0, 16'd0, 16'd0, 16'hFFFF, 16'd0, 16'd0, 16'd0, 16'd0};
        stream_frame(0);

        for (phase = 0; phase < 3; phase++) begin
            tx_idle_pct = (phase == 0) ? 24 : (phase == 1) ? 45 : 0;
            rx_idle_pct = (phase == 0) ? 45 : (phase == 1) ? 24 : 0;
            start_count = taken_items;
            while (taken_items - start_count < ITEMS_PER_PHASE) random_frame();
        end

        stop_sending();
        waited = 0;
        while (tracker.filtered_q.size() != 0 && waited < 20000) begin
            @(negedge aclk);
            waited++;
        end
        repeat (SETTLE_CYCLES) @(negedge aclk);
        if (tracker.filtered_q.size() != 0) begin
            $display("%0t ns: %0d expected pixels never came out",
                     $time, tracker.filtered_q.size());
            tracker.errors++;
        end
        if (tracker.errors == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    initial begin
        #60_000_000;
        $display("TEST FAILED");
        $finish;
    end

endmodule
